/* rtl/cfsr_pkg.sv */
package cfsr_pkg;

    // Angles are Q.24 radians carried in ANG_W signed bits.
    localparam int ANG_W = 28;
    // Periods never exceed 2*pi*2^24*256/16, which fits in PER_W unsigned bits.
    localparam int PER_W = 31;
    // Width of the constant numerators of the period division.
    localparam int NUM_W = 35;

    localparam logic [NUM_W-1:0] RAD_NUM   = 35'd26986075392;
    localparam logic [NUM_W-1:0] TEN_V_NUM = 35'd2621440;

    localparam logic signed [ANG_W-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] TWO_PI_S    = 28'sd105414357;
    localparam logic [PER_W-1:0]        TWO_PI_U    = 31'd105414357;

    localparam logic signed [24:0] KINV_Q24 = 25'sd10188014;

    typedef enum logic {
        FOLD_SQUARE = 1'b0,
        FOLD_RADIAL = 1'b1
    } fold_mode_t;

    typedef enum logic [1:0] {
        REG_FOLD_MODE    = 2'd0,
        REG_AMOUNT_BASE  = 2'd1,
        REG_AMOUNT_DEPTH = 2'd2
    } cfg_index_t;

    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ANG_W-1:0] res;
        unique case (idx)
            5'd0:  res = 28'sd13176795;
            5'd1:  res = 28'sd7778716;
            5'd2:  res = 28'sd4110060;
            5'd3:  res = 28'sd2086331;
            5'd4:  res = 28'sd1047214;
            5'd5:  res = 28'sd524117;
            5'd6:  res = 28'sd262123;
            5'd7:  res = 28'sd131069;
            5'd8:  res = 28'sd65536;
            5'd9:  res = 28'sd32768;
            5'd10: res = 28'sd16384;
            5'd11: res = 28'sd8192;
            5'd12: res = 28'sd4096;
            5'd13: res = 28'sd2048;
            5'd14: res = 28'sd1024;
            5'd15: res = 28'sd512;
            5'd16: res = 28'sd256;
            5'd17: res = 28'sd128;
            5'd18: res = 28'sd64;
            5'd19: res = 28'sd32;
            5'd20: res = 28'sd16;
            5'd21: res = 28'sd8;
            5'd22: res = 28'sd4;
            5'd23: res = 28'sd2;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/coordinate_fold_square_radial_top.sv */
// Coordinate folder: each transaction on the s_ side carries an x,y pair and an
// amount control voltage; each transaction on the m_ side carries the folded pair.
// One transaction is taken per clock unless a result waits on m_tready, and results
// come out in order, one per input. Input, blend and scale stages build the amount,
// a bit-per-stage divider forms the period, a vectoring CORDIC finds radius and
// angle, two more bit-per-stage dividers wrap the coordinates or the angle, five
// stages reduce the angle by 2*pi, and a rotating CORDIC converts back. The whole
// pipeline advances together and holds while a result waits on m_tready.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user must do
// so only while idle, as the block itself does not enforce it.
module coordinate_fold_square_radial_top #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_index,
    input  logic [11:0]                           cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // x_pos, y_pos, amount_cv from the lowest bit up, zero padded
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // x_folded, y_folded from the lowest bit up, zero padded
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata
);
    import cfsr_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int NS    = CORDIC_STAGES;
    localparam int SW    = ((SB + 11 > 23) ? SB + 11 : 23) + 1;
    localparam int AMT_W = SW - 11;
    localparam int CW    = SB + 7;
    localparam int DA    = (SB > ANG_W) ? SB : ANG_W;
    localparam int XW    = ((DA > PER_W) ? DA : PER_W) + 2;
    localparam int OW    = ((PER_W > SB) ? PER_W : SB) + 1;
    localparam int MT_W  = ((2*SB+7)/8)*8;
    localparam logic signed [CW+24:0] RND24 = (CW+25)'(2**23);

    typedef struct packed {
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
    } xy_t;

    typedef struct packed {
        logic signed [SB-1:0] x;
        logic signed [SB-1:0] y;
        logic [PER_W-1:0]     per;
    } vec_side_t;

    typedef struct packed {
        logic signed [DA:0]   aval;
        logic [PER_W-1:0]     per;
        logic signed [CW-1:0] c0;
        logic                 rz;
    } rem_side_t;

    typedef struct packed {
        logic [PER_W-1:0]     t;
        logic [PER_W-1:0]     wa;
        logic [PER_W-1:0]     wb;
        logic signed [CW-1:0] c0;
        logic                 rz;
    } mod_t;

    typedef struct packed {
        logic [PER_W-1:0] wa;
        logic [PER_W-1:0] wb;
        logic             rz;
    } rot_side_t;

    function automatic logic [DA-1:0] mag(input logic signed [DA:0] v);
        logic signed [DA:0] n;
        n = -v;
        return (v < 0) ? n[DA-1:0] : v[DA-1:0];
    endfunction

    // Wrap into (0,p] from above and [0,p) from below; values in [0,p] pass.
    function automatic logic [PER_W-1:0] wrap_fix(input logic signed [DA:0] av,
                                                  input logic [PER_W-1:0] m,
                                                  input logic [PER_W-1:0] p);
        logic signed [XW-1:0] av_x;
        logic signed [XW-1:0] p_x;
        logic [PER_W-1:0]     res;
        av_x = XW'(av);
        p_x  = $signed(XW'(p));
        if (av_x > p_x) begin
            res = (m == '0) ? p : m;
        end else if (av_x < 0) begin
            res = (m == '0) ? '0 : p - m;
        end else begin
            res = av_x[PER_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [SB-1:0] sat_u(input logic [PER_W-1:0] v);
        logic [OW-1:0] e;
        e = OW'(v);
        return (|e[OW-1:SB-1]) ? {1'b0, {(SB-1){1'b1}}} : e[SB-1:0];
    endfunction

    function automatic logic [SB-1:0] rnd_sat(input logic signed [CW-1:0] v);
        logic signed [CW:0]   e;
        logic signed [CW-4:0] r;
        logic [CW-3-SB:0]     upper;
        logic [SB-1:0]        res;
        e     = (CW+1)'(v) + (CW+1)'(8);
        r     = e[CW:4];
        upper = r[CW-4:SB-1];
        if ((&upper) || !(|upper)) begin
            res = r[SB-1:0];
        end else begin
            res = r[CW-4] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        return res;
    endfunction

    // Configuration registers.
    fold_mode_t  fold_mode_reg;
    logic [11:0] amount_base_reg;
    logic [8:0]  amount_depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_mode_reg    <= FOLD_SQUARE;
            amount_base_reg  <= 12'd256;
            amount_depth_reg <= 9'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FOLD_MODE:    fold_mode_reg    <= fold_mode_t'(cfg_wdata[0]);
                REG_AMOUNT_BASE:  amount_base_reg  <= cfg_wdata;
                REG_AMOUNT_DEPTH: amount_depth_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    logic radial;
    assign radial = (fold_mode_reg == FOLD_RADIAL);

    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Stage 1: input register.
    logic                 v1_reg;
    logic signed [SB-1:0] x1_reg, y1_reg, cv1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg  <= s_tdata[SB-1:0];
            y1_reg  <= s_tdata[2*SB-1:SB];
            cv1_reg <= s_tdata[3*SB-1:2*SB];
        end
    end

    // Stage 2: blend of base amount and control voltage.
    logic [8:0]            d_eff;
    logic [22:0]           term_b;
    logic signed [SB:0]    cv_off;
    logic signed [SB+10:0] term_c;
    logic signed [SW-1:0]  sum_next;
    logic                  v2_reg;
    logic signed [SW-1:0]  sum2_reg;
    xy_t                   xy2_reg;

    assign d_eff    = (amount_depth_reg > 9'd256) ? 9'd256 : amount_depth_reg;
    assign term_b   = {1'b0, 20'(amount_base_reg) * 20'(9'd256 - d_eff), 2'b00};
    assign cv_off   = (SB+1)'(cv1_reg) + (SB+1)'(1024);
    assign term_c   = (SB+11)'(cv_off) * $signed({1'b0, d_eff});
    assign sum_next = SW'(term_c) + $signed(SW'(term_b));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum2_reg <= sum_next;
            xy2_reg  <= '{x: x1_reg, y: y1_reg};
        end
    end

    // Stage 3: scale to Q.8 and hold at no less than 1/16.
    logic signed [SW-11:0] amt_sh;
    logic [AMT_W-1:0]      amt_next;
    logic                  v3_reg;
    logic [AMT_W-1:0]      amt3_reg;
    xy_t                   xy3_reg;

    assign amt_sh   = sum2_reg[SW-1:10];
    assign amt_next = (amt_sh < 16) ? AMT_W'(16) : amt_sh[AMT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            amt3_reg <= amt_next;
            xy3_reg  <= xy2_reg;
        end
    end

    // Period: square uses 10 V / amount, radial uses 2*pi / amount.
    logic             vd;
    logic [NUM_W-1:0] dq;
    xy_t              xyd;

    cfsr_div #(
        .N_W (NUM_W),
        .D_W (AMT_W),
        .S_W ($bits(xy_t))
    ) u_period_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v3_reg),
        .dividend  (radial ? RAD_NUM : TEN_V_NUM),
        .divisor   (amt3_reg),
        .side_i    (xy3_reg),
        .out_valid (vd),
        .quotient  (dq),
        .remainder (),
        .side_o    (xyd)
    );

    // Vectoring CORDIC on (y, x) scaled by 16; the left half-plane is
    // pre-rotated by pi.
    logic [PER_W-1:0]     per_d;
    logic signed [CW-1:0] a0, b0, p_in, q_in;
    logic signed [ANG_W-1:0] z_in;
    vec_side_t            vside_o;
    logic                 vv;
    logic signed [CW-1:0] va;
    logic signed [ANG_W-1:0] vz;

    assign per_d = (dq == '0) ? PER_W'(1) : dq[PER_W-1:0];
    assign a0    = CW'($signed({xyd.y, 4'b0000}));
    assign b0    = CW'($signed({xyd.x, 4'b0000}));
    assign p_in  = (a0 < 0) ? -a0 : a0;
    assign q_in  = (a0 < 0) ? -b0 : b0;
    assign z_in  = (a0 < 0) ? ((b0 >= 0) ? PI_Q24 : -PI_Q24) : '0;

    cfsr_cordic #(
        .W   (CW),
        .NS  (NS),
        .VEC (1'b1),
        .S_W ($bits(vec_side_t))
    ) u_vector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (vd),
        .p_i       (p_in),
        .q_i       (q_in),
        .z_i       (z_in),
        .side_i    (vec_side_t'{x: xyd.x, y: xyd.y, per: per_d}),
        .out_valid (vv),
        .p_o       (va),
        .q_o       (),
        .z_o       (vz),
        .side_o    (vside_o)
    );

    // Gain removal: radius r = a/K, then the rotation start value c0 = r/K.
    logic                    k1_v_reg, k2_v_reg, k3_v_reg, k4_v_reg;
    logic signed [CW+24:0]   k1_prod_reg, k3_prod_reg;
    logic signed [CW-1:0]    k2_r_reg, k4_c0_reg;
    logic                    k3_rz_reg, k4_rz_reg;
    vec_side_t               k1_side_reg, k2_side_reg, k3_side_reg, k4_side_reg;
    logic signed [ANG_W-1:0] k1_z_reg, k2_z_reg, k3_z_reg, k4_z_reg;
    logic signed [CW+24:0]   k1_prod_next, k2_sum, k3_prod_next, k4_sum;

    assign k1_prod_next = va * KINV_Q24;
    assign k2_sum       = k1_prod_reg + RND24;
    assign k3_prod_next = k2_r_reg * KINV_Q24;
    assign k4_sum       = k3_prod_reg + RND24;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_v_reg <= 1'b0;
            k2_v_reg <= 1'b0;
            k3_v_reg <= 1'b0;
            k4_v_reg <= 1'b0;
        end else if (adv) begin
            k1_v_reg <= vv;
            k2_v_reg <= k1_v_reg;
            k3_v_reg <= k2_v_reg;
            k4_v_reg <= k3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k1_prod_reg <= k1_prod_next;
            k1_side_reg <= vside_o;
            k1_z_reg    <= vz;
            k2_r_reg    <= k2_sum[CW+23:24];
            k2_side_reg <= k1_side_reg;
            k2_z_reg    <= k1_z_reg;
            k3_prod_reg <= k3_prod_next;
            k3_rz_reg   <= (k2_r_reg == '0);
            k3_side_reg <= k2_side_reg;
            k3_z_reg    <= k2_z_reg;
            k4_c0_reg   <= k4_sum[CW+23:24];
            k4_rz_reg   <= k3_rz_reg;
            k4_side_reg <= k3_side_reg;
            k4_z_reg    <= k3_z_reg;
        end
    end

    // Remainders against the period: x or the angle on one unit, y on the other.
    logic signed [DA:0] aval_k;
    logic signed [DA:0] yval_k;
    logic               ra_v;
    logic [PER_W-1:0]   ra_rem, rb_rem;
    rem_side_t          ra_side;
    logic signed [SB-1:0] rb_y;

    assign aval_k = radial ? (DA+1)'(k4_z_reg) : (DA+1)'(k4_side_reg.x);
    assign yval_k = (DA+1)'(k4_side_reg.y);

    cfsr_div #(
        .N_W (DA),
        .D_W (PER_W),
        .S_W ($bits(rem_side_t))
    ) u_rem_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (k4_v_reg),
        .dividend  (mag(aval_k)),
        .divisor   (k4_side_reg.per),
        .side_i    (rem_side_t'{aval: aval_k, per: k4_side_reg.per,
                                c0: k4_c0_reg, rz: k4_rz_reg}),
        .out_valid (ra_v),
        .quotient  (),
        .remainder (ra_rem),
        .side_o    (ra_side)
    );

    // Runs in lockstep with the first unit, so its valid output is not needed.
    cfsr_div #(
        .N_W (DA),
        .D_W (PER_W),
        .S_W (SB)
    ) u_rem_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (k4_v_reg),
        .dividend  (mag(yval_k)),
        .divisor   (k4_side_reg.per),
        .side_i    (k4_side_reg.y),
        .out_valid (),
        .quotient  (),
        .remainder (rb_rem),
        .side_o    (rb_y)
    );

    // Wrap correction, then reduction of the wrapped angle modulo 2*pi.
    logic mv_reg [6];
    mod_t mst_reg [6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg[0] <= 1'b0;
        end else if (adv) begin
            mv_reg[0] <= ra_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mst_reg[0].wa <= wrap_fix(ra_side.aval, ra_rem, ra_side.per);
            mst_reg[0].wb <= wrap_fix((DA+1)'(rb_y), rb_rem, ra_side.per);
            mst_reg[0].t  <= wrap_fix(ra_side.aval, ra_rem, ra_side.per);
            mst_reg[0].c0 <= ra_side.c0;
            mst_reg[0].rz <= ra_side.rz;
        end
    end

    for (genvar j = 0; j < 5; j++) begin : g_mod
        localparam logic [PER_W-1:0] LIM = TWO_PI_U << (4 - j);
        mod_t st_next;

        always_comb begin
            st_next = mst_reg[j];
            if (mst_reg[j].t >= LIM) begin
                st_next.t = mst_reg[j].t - LIM;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                mv_reg[j+1] <= 1'b0;
            end else if (adv) begin
                mv_reg[j+1] <= mv_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                mst_reg[j+1] <= st_next;
            end
        end
    end

    // Map the angle into (-pi, pi], then fold into the right half-plane.
    logic signed [ANG_W-1:0] ts, ts2, tq_next;
    logic signed [CW-1:0]    cq_next;
    logic                    q_v_reg;
    logic signed [ANG_W-1:0] tq_reg;
    logic signed [CW-1:0]    cq_reg;
    rot_side_t               q_side_reg;

    assign ts  = $signed({1'b0, mst_reg[5].t[ANG_W-2:0]});
    assign ts2 = (ts > PI_Q24) ? ts - TWO_PI_S : ts;

    always_comb begin
        tq_next = ts2;
        cq_next = mst_reg[5].c0;
        if (ts2 > HALF_PI_Q24) begin
            tq_next = ts2 - PI_Q24;
            cq_next = -mst_reg[5].c0;
        end else if (ts2 < -HALF_PI_Q24) begin
            tq_next = ts2 + PI_Q24;
            cq_next = -mst_reg[5].c0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_v_reg <= 1'b0;
        end else if (adv) begin
            q_v_reg <= mv_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tq_reg     <= tq_next;
            cq_reg     <= cq_next;
            q_side_reg <= '{wa: mst_reg[5].wa, wb: mst_reg[5].wb, rz: mst_reg[5].rz};
        end
    end

    // Rotating CORDIC back to x = r*sin, y = r*cos.
    logic                 rv;
    logic signed [CW-1:0] rc, rs;
    rot_side_t            rside;

    cfsr_cordic #(
        .W   (CW),
        .NS  (NS),
        .VEC (1'b0),
        .S_W ($bits(rot_side_t))
    ) u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (q_v_reg),
        .p_i       (cq_reg),
        .q_i       ('0),
        .z_i       (tq_reg),
        .side_i    (q_side_reg),
        .out_valid (rv),
        .p_o       (rc),
        .q_o       (rs),
        .z_o       (),
        .side_o    (rside)
    );

    // Output register.
    logic [SB-1:0] x_out_next, y_out_next;
    logic [SB-1:0] x_out_reg, y_out_reg;

    always_comb begin
        if (!radial) begin
            x_out_next = sat_u(rside.wa);
            y_out_next = sat_u(rside.wb);
        end else if (rside.rz) begin
            x_out_next = '0;
            y_out_next = '0;
        end else begin
            x_out_next = rnd_sat(rs);
            y_out_next = rnd_sat(rc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= rv;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_out_reg <= x_out_next;
            y_out_reg <= y_out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = MT_W'({y_out_reg, x_out_reg});

endmodule

/* rtl/cfsr_div.sv */
module cfsr_div #(
    parameter int N_W = 35,
    parameter int D_W = 16,
    parameter int S_W = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    input  logic [S_W-1:0] side_i,
    output logic           out_valid,
    output logic [N_W-1:0] quotient,
    output logic [D_W-1:0] remainder,
    output logic [S_W-1:0] side_o
);

    // Restoring division, one quotient bit per stage, most significant first.
    logic           vld_reg  [N_W];
    logic [N_W-1:0] num_reg  [N_W];
    logic [D_W-1:0] dvs_reg  [N_W];
    logic [D_W-1:0] rem_reg  [N_W];
    logic [N_W-1:0] quo_reg  [N_W];
    logic [S_W-1:0] side_reg [N_W];

    for (genvar k = 0; k < N_W; k++) begin : g_stage
        logic           vld_prev;
        logic [N_W-1:0] num_prev;
        logic [D_W-1:0] dvs_prev;
        logic [D_W-1:0] rem_prev;
        logic [N_W-1:0] quo_prev;
        logic [S_W-1:0] side_prev;
        logic [D_W:0]   trial;
        logic           take;
        logic [D_W-1:0] rem_next;
        logic [N_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign num_prev  = dividend;
            assign dvs_prev  = divisor;
            assign rem_prev  = '0;
            assign quo_prev  = '0;
            assign side_prev = side_i;
        end else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign num_prev  = num_reg[k-1];
            assign dvs_prev  = dvs_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        assign trial    = {rem_prev, num_prev[N_W-1-k]};
        assign take     = (trial >= {1'b0, dvs_prev});
        assign rem_next = take ? D_W'(trial - {1'b0, dvs_prev}) : trial[D_W-1:0];
        assign quo_next = {quo_prev[N_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (adv) begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                num_reg[k]  <= num_prev;
                dvs_reg[k]  <= dvs_prev;
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[N_W-1];
    assign quotient  = quo_reg[N_W-1];
    assign remainder = rem_reg[N_W-1];
    assign side_o    = side_reg[N_W-1];

endmodule

/* rtl/cfsr_cordic.sv */
module cfsr_cordic #(
    parameter int W   = 23,
    parameter int NS  = 16,
    parameter bit VEC = 1'b1,
    parameter int S_W = 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic signed [W-1:0]            p_i,
    input  logic signed [W-1:0]            q_i,
    input  logic signed [cfsr_pkg::ANG_W-1:0] z_i,
    input  logic [S_W-1:0]                 side_i,
    output logic                           out_valid,
    output logic signed [W-1:0]            p_o,
    output logic signed [W-1:0]            q_o,
    output logic signed [cfsr_pkg::ANG_W-1:0] z_o,
    output logic [S_W-1:0]                 side_o
);
    import cfsr_pkg::*;

    logic                    vld_reg  [NS];
    logic signed [W-1:0]     p_reg    [NS];
    logic signed [W-1:0]     q_reg    [NS];
    logic signed [ANG_W-1:0] z_reg    [NS];
    logic [S_W-1:0]          side_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic                    vld_prev;
        logic signed [W-1:0]     p_prev;
        logic signed [W-1:0]     q_prev;
        logic signed [ANG_W-1:0] z_prev;
        logic [S_W-1:0]          side_prev;
        logic                    plus;
        logic signed [W-1:0]     p_next;
        logic signed [W-1:0]     q_next;
        logic signed [ANG_W-1:0] z_next;

        if (i == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign p_prev    = p_i;
            assign q_prev    = q_i;
            assign z_prev    = z_i;
            assign side_prev = side_i;
        end else begin : g_next
            assign vld_prev  = vld_reg[i-1];
            assign p_prev    = p_reg[i-1];
            assign q_prev    = q_reg[i-1];
            assign z_prev    = z_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // Vectoring drives q toward zero; rotation drives the angle toward zero.
        // Both reduce to the same micro-rotation with a different sign source.
        if (VEC) begin : g_vec
            assign plus = (q_prev >= 0);
        end else begin : g_rot
            assign plus = (z_prev < 0);
        end

        assign p_next = plus ? p_prev + (q_prev >>> i) : p_prev - (q_prev >>> i);
        assign q_next = plus ? q_prev - (p_prev >>> i) : q_prev + (p_prev >>> i);
        assign z_next = plus ? z_prev + atan_q24(5'(i)) : z_prev - atan_q24(5'(i));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (adv) begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                p_reg[i]    <= p_next;
                q_reg[i]    <= q_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign p_o       = p_reg[NS-1];
    assign q_o       = q_reg[NS-1];
    assign z_o       = z_reg[NS-1];
    assign side_o    = side_reg[NS-1];

endmodule

/* bench/tb.sv */
module tb;
    import cfsr_pkg::*;

    localparam int SB = 16;
    localparam int STAGES = 16;
    localparam int LATENCY = 110;
    localparam longint CYCLE_LIMIT = 1500000;

    localparam longint PI_C = 52707179;
    localparam longint TWO_PI_C = 105414357;
    localparam longint HALF_PI_C = 26353589;
    localparam longint KINV_C = 10188014;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [11:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    longint cycle_count = 0;
    int items_sent = 0;

    coordinate_fold_square_radial_top #(.SAMPLE_BITS(SB), .CORDIC_STAGES(STAGES)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Floor shift that is safe for negative values.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap_period(longint a, longint p);
        longint r;
        if (a > p) begin
            r = a % p;
            return (r == 0) ? p : r;
        end
        if (a < 0) begin
            r = a % p;
            return (r < 0) ? r + p : r;
        end
        return a;
    endfunction

    function automatic logic [15:0] saturate16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    class fold_scoreboard;
        logic [31:0] folded_q[$];
        fold_mode_t mode = FOLD_SQUARE;
        int unsigned base = 256;
        int unsigned depth = 0;
        int errors = 0;
        int checked = 0;

        function void polar_fold(longint x, longint y, longint amt,
                                 output longint xo, output longint yo);
            longint a, b, z, na, nb, r, per, t, c, s, nc;
            a = y * 16;
            b = x * 16;
            z = 0;
            if (a < 0) begin
                z = (b >= 0) ? PI_C : -PI_C;
                a = -a;
                b = -b;
            end
            for (int i = 0; i < STAGES; i++) begin
                if (b >= 0) begin
                    na = a + floor_shift(b, i);
                    nb = b - floor_shift(a, i);
                    z += atan_q24(i[4:0]);
                end else begin
                    na = a - floor_shift(b, i);
                    nb = b + floor_shift(a, i);
                    z -= atan_q24(i[4:0]);
                end
                a = na;
                b = nb;
            end
            r = floor_shift(a * KINV_C + (64'sd1 << 23), 24);
            per = (TWO_PI_C * 256) / amt;
            if (per < 1) per = 1;
            t = wrap_period(z, per) % TWO_PI_C;
            if (t > PI_C) t -= TWO_PI_C;
            c = floor_shift(r * KINV_C + (64'sd1 << 23), 24);
            if (t > HALF_PI_C) begin
                t -= PI_C;
                c = -c;
            end else if (t < -HALF_PI_C) begin
                t += PI_C;
                c = -c;
            end
            s = 0;
            for (int i = 0; i < STAGES; i++) begin
                if (t >= 0) begin
                    nc = c - floor_shift(s, i);
                    s = s + floor_shift(c, i);
                    t -= atan_q24(i[4:0]);
                end else begin
                    nc = c + floor_shift(s, i);
                    s = s - floor_shift(c, i);
                    t += atan_q24(i[4:0]);
                end
                c = nc;
            end
            if (r == 0) begin
                c = 0;
                s = 0;
            end
            xo = floor_shift(s + 8, 4);
            yo = floor_shift(c + 8, 4);
        endfunction

        function void note_input(logic [47:0] d);
            longint x, y, cv, dp, amt, p, xo, yo;
            x = longint'($signed(d[15:0]));
            y = longint'($signed(d[31:16]));
            cv = longint'($signed(d[47:32]));
            dp = (depth > 256) ? 256 : depth;
            amt = floor_shift(longint'(base) * (256 - dp) * 4 + (cv + 1024) * dp, 10);
            if (amt < 16) amt = 16;
            if (mode == FOLD_SQUARE) begin
                p = 2621440 / amt;
                if (p < 1) p = 1;
                xo = wrap_period(x, p);
                yo = wrap_period(y, p);
            end else begin
                polar_fold(x, y, amt, xo, yo);
            end
            folded_q.push_back({saturate16(yo), saturate16(xo)});
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (folded_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = folded_q.pop_front();
            checked++;
            if (got[15:0] !== want[15:0]) begin
                $display("%0t: x_folded expected %h actual %h", $time, want[15:0], got[15:0]);
                errors++;
            end
            if (got[31:16] !== want[31:16]) begin
                $display("%0t: y_folded expected %h actual %h", $time, want[31:16], got[31:16]);
                errors++;
            end
        endfunction
    endclass

    fold_scoreboard sb = new();

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && s_tvalid && s_tready) sb.note_input(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("coordinate_fold_square_radial_top verification failed");
            $finish;
        end
    end

    // Receiver stalls at random according to the current percentage.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(cfg_index_t idx, logic [11:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FOLD_MODE:    sb.mode = fold_mode_t'(val[0]);
            REG_AMOUNT_BASE:  sb.base = val;
            REG_AMOUNT_DEPTH: sb.depth = val[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [11:0] mode, logic [11:0] base, logic [11:0] depth);
        while (sb.folded_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        write_reg(REG_FOLD_MODE, mode);
        write_reg(REG_AMOUNT_BASE, base);
        write_reg(REG_AMOUNT_DEPTH, depth);
    endtask

    // Holds tvalid until the transaction is taken; idle gaps may come before each item.
    task automatic send_item(logic [15:0] x, logic [15:0] y, logic [15:0] cv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cv, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic directed_set();
        send_item(16'h0000, 16'h0000, 16'h0000);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(16'h8000, 16'h8000, 16'h8000);
        send_item(16'h7FFF, 16'h8000, 16'h0000);
        send_item(16'h8000, 16'h7FFF, 16'hFC00);
        send_item(16'h0400, 16'h0000, 16'h0400);
        send_item(16'h0000, 16'hFC00, 16'h2000);
        send_item(16'hFC00, 16'h0400, 16'hF000);
        send_item(16'h2800, 16'h1400, 16'h0000);
        send_item(16'h0001, 16'hFFFF, 16'h0001);
        s_tvalid <= 1'b0;
    endtask

    task automatic random_burst(int n);
        logic [15:0] x, y;
        for (int i = 0; i < n; i++) begin
            x = $urandom;
            y = $urandom;
            // Keep many samples inside a few periods so the fold region is exercised.
            if ($urandom_range(3) == 0) begin
                x = $signed(x) >>> $urandom_range(6, 1);
                y = $signed(y) >>> $urandom_range(6, 1);
            end
            send_item(x, y, $urandom);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int errs_total;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part across extremes of the registers.
        apply_settings(FOLD_SQUARE, 256, 0);
        directed_set();
        apply_settings(FOLD_RADIAL, 256, 0);
        directed_set();
        apply_settings(FOLD_SQUARE, 4095, 511);
        directed_set();
        apply_settings(12'h003, 0, 256);
        directed_set();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph / 4)
                0: begin send_idle_pct = 33; recv_idle_pct = 62; end
                1: begin send_idle_pct = 62; recv_idle_pct = 33; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (ph % 4)
                0: apply_settings(FOLD_SQUARE, 256, 0);
                1: apply_settings(FOLD_RADIAL, 2816, 256);
                2: apply_settings($urandom, $urandom, $urandom_range(511));
                default: apply_settings(FOLD_RADIAL, $urandom_range(2816, 256),
                                        $urandom_range(256));
            endcase
            random_burst(110);
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (sb.folded_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 20) @(negedge aclk);
        errs_total = sb.errors;
        $display("Sent %0d items over square and radial folds with varied amounts;",
                 items_sent);
        $display("checked %0d results under sender and receiver stalls.", sb.checked);
        if (errs_total == 0) begin
            $display("coordinate_fold_square_radial_top verification clean");
        end else begin
            $display("coordinate_fold_square_radial_top verification failed");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/cfsr_pkg.sv
rtl/cfsr_div.sv
rtl/cfsr_cordic.sv
rtl/coordinate_fold_square_radial_top.sv
bench/tb.sv
